@@ sv/spq_pkg.sv @@
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int ID_W  = 8;
    localparam int OCC_W = 5;
    localparam int STS_W = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STS_W-1:0] STS_DONE      = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL_DROP = 2'd1;
    localparam logic [STS_W-1:0] STS_POP_EMPTY = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  thr;
        logic [ID_W-1:0]  prc;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry fresh;
    } t_cmd;

endpackage

@@ sv/sorted_priority_queue.sv @@
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_ready  | i_operation, i_arrival_key, i_thread_id,
//         |           |                    | i_process_id
// result  | out       | o_valid / i_ready  | o_head_valid, o_head_key, o_head_thread,
//         |           |                    | o_head_process, o_occupancy, o_status
//
// one item per cycle: every cell compares against the new key at once and
// shifts in the same clock, the result appears the cycle after acceptance.
// a stalled result holds the input side; a new item is taken in the cycle
// the pending result leaves. reset (synchronous, active low) empties the row.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_operation,
    input  logic [KEY_W-1:0] i_arrival_key,
    input  logic [ID_W-1:0]  i_thread_id,
    input  logic [ID_W-1:0]  i_process_id,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_head_valid,
    output logic [KEY_W-1:0] o_head_key,
    output logic [ID_W-1:0]  o_head_thread,
    output logic [ID_W-1:0]  o_head_process,
    output logic [OCC_W-1:0] o_occupancy,
    output logic [STS_W-1:0] o_status
);

    logic             accept;
    logic             full;
    logic             empty;
    t_cmd             cmd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic [STS_W-1:0] r_status;
    logic [STS_W-1:0] n_status;

    t_entry cell_entry [DEPTH];
    logic   cell_valid [DEPTH];
    logic   cell_ge    [DEPTH];

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);

    always_comb begin
        cmd.fresh.key = i_arrival_key;
        cmd.fresh.thr = i_thread_id;
        cmd.fresh.prc = i_process_id;
        cmd.push      = accept && (i_operation == OP_PUSH) && !full;
        cmd.pop       = accept && (i_operation == OP_POP) && !empty;
        n_count       = r_count;
        n_status      = STS_DONE;
        if (cmd.push) begin
            n_count = r_count + 1'b1;
        end else if (cmd.pop) begin
            n_count = r_count - 1'b1;
        end
        if (i_operation == OP_PUSH && full) begin
            n_status = STS_FULL_DROP;
        end else if (i_operation == OP_POP && empty) begin
            n_status = STS_POP_EMPTY;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry left;
        logic   left_valid;
        logic   left_ge;
        t_entry right;
        logic   right_valid;

        if (g == 0) begin : g_first
            assign left       = cmd.fresh;
            assign left_valid = 1'b1;
            assign left_ge    = 1'b0;
        end else begin : g_mid
            assign left       = cell_entry[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_ge    = cell_ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right       = cmd.fresh;
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right       = cell_entry[g+1];
            assign right_valid = cell_valid[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_strict      (g == 0),
            .i_left        (left),
            .i_left_valid  (left_valid),
            .i_left_ge     (left_ge),
            .i_right       (right),
            .i_right_valid (right_valid),
            .o_entry       (cell_entry[g]),
            .o_valid       (cell_valid[g]),
            .o_ge          (cell_ge[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_status    <= STS_DONE;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // head cell only changes on acceptance, so it stays put while a result waits
    assign o_valid        = r_out_valid;
    assign o_head_valid   = cell_valid[0];
    assign o_head_key     = cell_valid[0] ? cell_entry[0].key : '0;
    assign o_head_thread  = cell_valid[0] ? cell_entry[0].thr : '0;
    assign o_head_process = cell_valid[0] ? cell_entry[0].prc : '0;
    assign o_occupancy    = OCC_W'(r_count);
    assign o_status       = r_status;

endmodule

@@ sv/spq_cell.sv @@
module spq_cell
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  logic   i_strict,
    input  t_entry i_left,
    input  logic   i_left_valid,
    input  logic   i_left_ge,
    input  t_entry i_right,
    input  logic   i_right_valid,
    output t_entry o_entry,
    output logic   o_valid,
    output logic   o_ge
);

    t_entry r_entry;
    logic   r_valid;
    t_entry n_entry;
    logic   n_valid;
    logic   cmp;

    // head displaced only on strictly greater key, others on greater or equal
    assign cmp  = i_strict ? (r_entry.key > i_cmd.fresh.key)
                           : (r_entry.key >= i_cmd.fresh.key);
    assign o_ge = !r_valid || cmp;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_cmd.push) begin
            if (o_ge && !i_left_ge) begin
                n_entry = i_cmd.fresh;
            end else if (o_ge) begin
                n_entry = i_left;
            end
            n_valid = r_valid || i_left_valid;
        end else if (i_cmd.pop) begin
            n_entry = i_right;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

@@ sv/spq_checker.sv @@
module spq_checker
    import spq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_head_valid,
    input logic [KEY_W-1:0] o_head_key,
    input logic [OCC_W-1:0] o_occupancy,
    input logic [STS_W-1:0] o_status
);

    a_head_matches_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_head_valid == (o_occupancy != '0)))
        else $error("head valid disagrees with occupancy");

    a_full_drop_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STS_FULL_DROP) |-> (o_occupancy == OCC_W'(DEPTH)))
        else $error("full drop reported below capacity");

    a_pop_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STS_POP_EMPTY) |-> (o_occupancy == '0 && !o_head_valid))
        else $error("pop on empty reported with entries held");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STS_DONE || o_status == STS_FULL_DROP
                     || o_status == STS_POP_EMPTY))
        else $error("undefined status code");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_head_key)
                                   && $stable(o_occupancy) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_head_valid (o_head_valid),
    .o_head_key   (o_head_key),
    .o_occupancy  (o_occupancy),
    .o_status     (o_status)
);
